/* rtl/rrva_pkg.sv */
// rrva_pkg: shared constants, codes and types of the voice allocator
// used by every rtl file of the block, no dependencies

package rrva_pkg;

   localparam int VOICES = 16;
   localparam int IDX_W  = $clog2(VOICES);
   localparam int CNT_W  = $clog2(VOICES + 1);

   localparam int CMD_W  = 2;
   localparam int KEY_W  = 7;
   localparam int VEL_W  = 7;
   localparam int DONE_W = 4;
   localparam int VIDX_W = 4;
   localparam int ACT_W  = 2;
   localparam int CSR_W  = 5;

   localparam logic [CSR_W-1:0] ACTIVE_RESET = CSR_W'(VOICES);

   localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DONE     = 2'd2;

   localparam logic [ACT_W-1:0] ACT_FRESH   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RETRIG  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;
   localparam logic [ACT_W-1:0] ACT_NONE    = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // search token that walks the cell chain
   typedef struct packed {
      logic             valid;
      logic             is_on;
      logic [KEY_W-1:0] key;
      logic             found;
      logic [IDX_W-1:0] idx;
   } token_type;

   // broadcast update of one cell
   typedef struct packed {
      logic             start;
      logic             clear;
      logic [IDX_W-1:0] idx;
      logic [KEY_W-1:0] key;
   } cell_wr_type;

endpackage

/* rtl/rrva_if.sv */
// rrva_req_if, rrva_rsp_if: valid/ready channels of the voice allocator
// depends on rrva_pkg

interface rrva_req_if;
   logic                        valid;
   logic                        ready;
   logic [rrva_pkg::CMD_W-1:0]  cmd;
   logic [rrva_pkg::KEY_W-1:0]  note_key;
   logic [rrva_pkg::VEL_W-1:0]  note_velocity;
   logic [rrva_pkg::DONE_W-1:0] done_voice;

   modport source (output valid, cmd, note_key, note_velocity, done_voice, input ready);
   modport sink (input valid, cmd, note_key, note_velocity, done_voice, output ready);
endinterface

interface rrva_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rrva_pkg::VIDX_W-1:0] voice_index;
   logic [rrva_pkg::ACT_W-1:0]  action;
   logic                        stolen;
   logic [rrva_pkg::KEY_W-1:0]  out_key;
   logic [rrva_pkg::VEL_W-1:0]  out_velocity;

   modport source (output valid, voice_index, action, stolen, out_key, out_velocity,
                   input ready);
   modport sink (input valid, voice_index, action, stolen, out_key, out_velocity,
                 output ready);
endinterface

/* rtl/rrva_cell.sv */
// rrva_cell: one voice slot (key, in-use, key-down) and one stage of the search chain
// depends on rrva_pkg

module rrva_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [rrva_pkg::IDX_W-1:0] my_index,
   input  logic [rrva_pkg::CNT_W-1:0] count,
   input  rrva_pkg::token_type        tok_in,
   output rrva_pkg::token_type        tok_out,
   input  rrva_pkg::cell_wr_type      wr,
   output logic                       in_use
);

   logic [rrva_pkg::KEY_W-1:0] key_ff;
   logic                       in_use_ff;
   logic                       key_down_ff;
   rrva_pkg::token_type        tok_ff;
   rrva_pkg::token_type        tok_in_w;
   logic                       active;
   logic                       hit;
   logic                       sel;

   assign active = {1'b0, my_index} < count;
   assign hit    = tok_in.valid && active && in_use_ff && (key_ff == tok_in.key);
   assign sel    = wr.idx == my_index;

   always_comb begin
      tok_in_w = tok_in;
      if (hit && !tok_in.found) begin
         tok_in_w.found = 1'b1;
         tok_in_w.idx   = my_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff    <= 1'b0;
         key_down_ff  <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_w;
         if (wr.start && sel) begin
            key_ff      <= wr.key;
            in_use_ff   <= 1'b1;
            key_down_ff <= 1'b1;
         end else if (wr.clear && sel) begin
            in_use_ff <= 1'b0;
         end else if (hit && !tok_in.is_on) begin
            key_down_ff <= 1'b0;
         end
      end
   end

   assign tok_out = tok_ff;
   assign in_use  = in_use_ff;

endmodule

/* rtl/rrva_ctrl.sv */
// rrva_ctrl: command sequencer, round-robin pointer, voice count register
// and result register; depends on rrva_pkg and rrva_if

module rrva_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   rrva_req_if.sink                    req,
   rrva_rsp_if.source                  rsp,
   input  logic                        csr_we,
   input  logic [rrva_pkg::CSR_W-1:0]  csr_wdata,
   output logic [rrva_pkg::CNT_W-1:0]  count,
   output rrva_pkg::token_type         inject,
   input  rrva_pkg::token_type         chain_end,
   input  logic [rrva_pkg::VOICES-1:0] use_vec,
   output rrva_pkg::cell_wr_type       wr
);

   rrva_pkg::state_type        state_ff, state_in;
   logic [rrva_pkg::CSR_W-1:0] active_ff;
   logic [rrva_pkg::IDX_W-1:0] next_slot_ff, next_slot_in;
   logic                       op_on_ff;
   logic [rrva_pkg::KEY_W-1:0] key_ff;
   logic [rrva_pkg::VEL_W-1:0] vel_ff;
   logic                       found_ff;
   logic [rrva_pkg::IDX_W-1:0] hit_idx_ff;

   logic                        rsp_valid_ff;
   logic [rrva_pkg::VIDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [rrva_pkg::ACT_W-1:0]  rsp_act_ff, rsp_act_in;
   logic                        rsp_st_ff, rsp_st_in;
   logic [rrva_pkg::KEY_W-1:0]  rsp_key_ff;
   logic [rrva_pkg::VEL_W-1:0]  rsp_vel_ff, rsp_vel_in;

   logic                       accept;
   logic                       is_note;
   logic                       out_free;
   logic                       commit;
   logic [rrva_pkg::IDX_W-1:0] rr_slot;
   logic [rrva_pkg::CNT_W-1:0] rr_plus;

   // saturate voice count to 1..VOICES
   always_comb begin
      if (active_ff == '0) begin
         count = rrva_pkg::CNT_W'(1);
      end else if (32'(active_ff) > rrva_pkg::VOICES) begin
         count = rrva_pkg::CNT_W'(rrva_pkg::VOICES);
      end else begin
         count = rrva_pkg::CNT_W'(active_ff);
      end
   end

   assign accept   = req.valid && req.ready;
   assign is_note  = (req.cmd == rrva_pkg::CMD_NOTE_ON) || (req.cmd == rrva_pkg::CMD_NOTE_OFF);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign commit   = (state_ff == rrva_pkg::ST_FINISH) && out_free;

   assign rr_slot = ({1'b0, next_slot_ff} < count) ? next_slot_ff : '0;
   assign rr_plus = {1'b0, rr_slot} + rrva_pkg::CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrva_pkg::ST_IDLE: begin
            if (accept && is_note) state_in = rrva_pkg::ST_SCAN;
         end
         rrva_pkg::ST_SCAN: begin
            if (chain_end.valid) state_in = rrva_pkg::ST_FINISH;
         end
         rrva_pkg::ST_FINISH: begin
            if (out_free) state_in = rrva_pkg::ST_IDLE;
         end
         default: state_in = rrva_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready    = 1'b0;
      inject       = '0;
      wr           = '0;
      next_slot_in = next_slot_ff;
      rsp_idx_in   = '0;
      rsp_act_in   = rrva_pkg::ACT_NONE;
      rsp_st_in    = 1'b0;
      rsp_vel_in   = '0;
      case (state_ff)
         rrva_pkg::ST_IDLE: begin
            req.ready    = 1'b1;
            inject.valid = accept && is_note;
            inject.is_on = req.cmd == rrva_pkg::CMD_NOTE_ON;
            inject.key   = req.note_key;
            if (accept && (req.cmd == rrva_pkg::CMD_DONE) &&
                (32'(req.done_voice) < rrva_pkg::VOICES)) begin
               wr.clear = 1'b1;
               wr.idx   = rrva_pkg::IDX_W'(req.done_voice);
            end
         end
         rrva_pkg::ST_SCAN: begin
         end
         rrva_pkg::ST_FINISH: begin
            if (op_on_ff) begin
               wr.key = key_ff;
               rsp_vel_in = vel_ff;
               if (found_ff) begin
                  wr.idx     = hit_idx_ff;
                  rsp_idx_in = rrva_pkg::VIDX_W'(hit_idx_ff);
                  rsp_act_in = rrva_pkg::ACT_RETRIG;
               end else begin
                  wr.idx       = rr_slot;
                  rsp_idx_in   = rrva_pkg::VIDX_W'(rr_slot);
                  rsp_act_in   = rrva_pkg::ACT_FRESH;
                  rsp_st_in    = use_vec[rr_slot];
                  next_slot_in = (rr_plus >= count) ? '0 : rr_plus[rrva_pkg::IDX_W-1:0];
               end
               wr.start = commit;
               if (!commit) next_slot_in = next_slot_ff;
            end else if (found_ff) begin
               rsp_idx_in = rrva_pkg::VIDX_W'(hit_idx_ff);
               rsp_act_in = rrva_pkg::ACT_RELEASE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrva_pkg::ST_IDLE;
         active_ff    <= rrva_pkg::ACTIVE_RESET;
         next_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_slot_ff <= next_slot_in;
         if (csr_we) active_ff <= csr_wdata;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_note) begin
         op_on_ff <= req.cmd == rrva_pkg::CMD_NOTE_ON;
         key_ff   <= req.note_key;
         vel_ff   <= req.note_velocity;
      end
      if (state_ff == rrva_pkg::ST_SCAN && chain_end.valid) begin
         found_ff   <= chain_end.found;
         hit_idx_ff <= chain_end.idx;
      end
      if (commit) begin
         rsp_idx_ff <= rsp_idx_in;
         rsp_act_ff <= rsp_act_in;
         rsp_st_ff  <= rsp_st_in;
         rsp_vel_ff <= rsp_vel_in;
         rsp_key_ff <= key_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.voice_index  = rsp_idx_ff;
   assign rsp.action       = rsp_act_ff;
   assign rsp.stolen       = rsp_st_ff;
   assign rsp.out_key      = rsp_key_ff;
   assign rsp.out_velocity = rsp_vel_ff;

endmodule

/* rtl/round_robin_voice_allocator_core.sv */
// round_robin_voice_allocator_core: top level, chain of voice cells plus sequencer
// depends on rrva_pkg, rrva_if, rrva_cell, rrva_ctrl
//
//   channel    dir   signals                                    transfer
//   req_chan   in    cmd, note_key, note_velocity, done_voice  valid & ready
//   rsp_chan   out   voice_index, action, stolen, out_key,     valid & ready
//                    out_velocity
//   csr        in    csr_we, csr_wdata (active_voices)         csr_we
//
// note on / note off: one transfer in, a search token walks all 16 cells one per
// cycle, then a finish step starts the voice on a note on and loads the result
// voice done and unknown commands are taken without a search and give no result
// the result register lets the next request in while a result waits; a held
// result stalls only the finish step of the following note event
// reset clears in-use, key-down, the round-robin pointer and sets 16 voices

module round_robin_voice_allocator_core (
   input  logic                       clock,
   input  logic                       reset,
   rrva_req_if.sink                   req_chan,
   rrva_rsp_if.source                 rsp_chan,
   input  logic                       csr_we,
   input  logic [rrva_pkg::CSR_W-1:0] csr_wdata
);

   rrva_pkg::token_type         tok [rrva_pkg::VOICES+1];
   rrva_pkg::cell_wr_type       wr;
   logic [rrva_pkg::CNT_W-1:0]  count;
   logic [rrva_pkg::VOICES-1:0] use_vec;

   rrva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .count     (count),
      .inject    (tok[0]),
      .chain_end (tok[rrva_pkg::VOICES]),
      .use_vec   (use_vec),
      .wr        (wr)
   );

   for (genvar i = 0; i < rrva_pkg::VOICES; i++) begin : g_cell
      rrva_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .my_index (rrva_pkg::IDX_W'(i)),
         .count    (count),
         .tok_in   (tok[i]),
         .tok_out  (tok[i+1]),
         .wr       (wr),
         .in_use   (use_vec[i])
      );
   end

endmodule

/* rtl/rrva_checker.sv */
// rrva_checker: port-level checks of the voice allocator, bound to the top level
// depends on rrva_pkg and round_robin_voice_allocator_core

module rrva_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [rrva_pkg::CMD_W-1:0]  req_cmd,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rrva_pkg::VIDX_W-1:0] rsp_voice_index,
   input logic [rrva_pkg::ACT_W-1:0]  rsp_action,
   input logic                        rsp_stolen,
   input logic [rrva_pkg::VEL_W-1:0]  rsp_out_velocity
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_note_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_cmd == rrva_pkg::CMD_NOTE_ON || req_cmd == rrva_pkg::CMD_NOTE_OFF)
      |=> !req_ready)
      else $error("request taken during a voice search");

   a_steal_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stolen |-> rsp_action == rrva_pkg::ACT_FRESH)
      else $error("steal flagged on a non-fresh start");

   a_release_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == rrva_pkg::ACT_RELEASE || rsp_action == rrva_pkg::ACT_NONE)
      |-> rsp_out_velocity == '0)
      else $error("velocity on a release result");

   a_none_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == rrva_pkg::ACT_NONE |-> rsp_voice_index == '0)
      else $error("no-match result with nonzero voice");

endmodule

bind round_robin_voice_allocator_core rrva_checker u_rrva_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_cmd          (req_chan.cmd),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_voice_index  (rsp_chan.voice_index),
   .rsp_action       (rsp_chan.action),
   .rsp_stolen       (rsp_chan.stolen),
   .rsp_out_velocity (rsp_chan.out_velocity)
);
